@@ hw/rtl/cdrd_pkg.sv @@
// Shared types and constants for the CANopen drive response decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cdrd_pkg;

  // Field widths of one received frame and of one result
  localparam int unsigned COB_ID_W  = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TORQUE_W  = 16;
  localparam int unsigned NODE_ID_W = 7;

  // Configuration port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic [0:0]  REG_NODE_ID = 1'b0;
  localparam logic [NODE_ID_W-1:0] NODE_ID_RESET = 7'd1;

  // COB-ID bases
  localparam logic [COB_ID_W-1:0] EMCY_BASE   = 11'h080;
  localparam logic [COB_ID_W-1:0] SDO_TX_BASE = 11'h580;
  localparam logic [COB_ID_W-1:0] HB_BASE     = 11'h700;

  // Object dictionary indexes
  localparam logic [INDEX_W-1:0] OBJ_VELOCITY = 16'h606C;
  localparam logic [INDEX_W-1:0] OBJ_TORQUE   = 16'h6077;
  localparam logic [INDEX_W-1:0] OBJ_WARNING  = 16'h2027;
  localparam logic [INDEX_W-1:0] OBJ_ERROR    = 16'h603F;
  localparam logic [INDEX_W-1:0] OBJ_STATUS   = 16'h6041;

  // NMT heartbeat state bytes
  localparam logic [BYTE_W-1:0] NMT_BOOTUP  = 8'h00;
  localparam logic [BYTE_W-1:0] NMT_STOPPED = 8'h04;
  localparam logic [BYTE_W-1:0] NMT_OPER    = 8'h05;
  localparam logic [BYTE_W-1:0] NMT_PREOP   = 8'h7F;

  // Statusword low nibble patterns
  localparam logic [3:0] SW_NOT_READY = 4'b0000;
  localparam logic [3:0] SW_READY     = 4'b0001;
  localparam logic [3:0] SW_SWITCHED  = 4'b0011;
  localparam logic [3:0] SW_ENABLED   = 4'b0111;
  localparam logic [3:0] SW_REACTION  = 4'b1111;
  localparam logic [3:0] SW_FAULT     = 4'b1000;
  localparam int unsigned SW_BIT_QSTOP   = 5;
  localparam int unsigned SW_BIT_SOD     = 6;

  typedef enum logic [1:0] {
    FC_UNKNOWN = 2'd0,
    FC_EMCY    = 2'd1,
    FC_SDO     = 2'd2,
    FC_HB      = 2'd3
  } frame_class_t;

  typedef enum logic [2:0] {
    DS_NOT_READY = 3'd0,
    DS_SOD       = 3'd1,
    DS_READY     = 3'd2,
    DS_SWITCHED  = 3'd3,
    DS_ENABLED   = 3'd4,
    DS_QSTOP     = 3'd5,
    DS_REACTION  = 3'd6,
    DS_FAULT     = 3'd7
  } drive_state_t;

  typedef enum logic [2:0] {
    HB_NONE    = 3'd0,
    HB_BOOTUP  = 3'd1,
    HB_STOPPED = 3'd2,
    HB_OPER    = 3'd3,
    HB_PREOP   = 3'd4,
    HB_OTHER   = 3'd5
  } hb_state_t;

  typedef struct packed {
    logic [COB_ID_W-1:0] cob_id;
    logic [BYTE_W-1:0]   first_byte;
    logic [INDEX_W-1:0]  object_index;
    logic [BYTE_W-1:0]   object_subindex;
    logic [DATA_W-1:0]   payload;
  } frame_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   velocity;
    logic signed [TORQUE_W-1:0] torque;
    logic                       failed;
    drive_state_t               drive_state;
  } drive_t;

  typedef struct packed {
    frame_class_t frame_class;
    logic         status_unknown;
    hb_state_t    heartbeat_state;
  } flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/cdrd_frame_if.sv @@
// Valid/ready channel carrying one received CAN frame per beat.
// Depends on cdrd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdrd_frame_if
  import cdrd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COB_ID_W-1:0] cob_id;
  logic [BYTE_W-1:0]   first_byte;
  logic [INDEX_W-1:0]  object_index;
  logic [BYTE_W-1:0]   object_subindex;
  logic [DATA_W-1:0]   payload;

  modport source (
    output valid, cob_id, first_byte, object_index, object_subindex, payload,
    input  ready
  );
  modport sink (
    input  valid, cob_id, first_byte, object_index, object_subindex, payload,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/cdrd_result_if.sv @@
// Valid/ready channel carrying one decode result per beat.
// Depends on cdrd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdrd_result_if
  import cdrd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 frame_class;
  logic signed [DATA_W-1:0]   velocity;
  logic signed [TORQUE_W-1:0] torque;
  logic                       failed;
  logic [2:0]                 drive_state;
  logic                       status_unknown;
  logic [2:0]                 heartbeat_state;

  modport source (
    output valid, frame_class, velocity, torque, failed, drive_state,
           status_unknown, heartbeat_state,
    input  ready
  );
  modport sink (
    input  valid, frame_class, velocity, torque, failed, drive_state,
           status_unknown, heartbeat_state,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/cdrd_decode.sv @@
// Combinational frame decode: classifies one frame and computes the next drive state.
// Depends on cdrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdrd_decode
  import cdrd_pkg::*;
(
  input  wire logic [NODE_ID_W-1:0] node_id,
  input  wire frame_t               frame,
  input  wire drive_t               cur,
  output drive_t                    nxt,
  output flags_t                    flags
);

  logic [COB_ID_W-1:0] node_ext;
  logic                is_emcy;
  logic                is_sdo;
  logic                is_hb;
  logic                sub_zero;
  logic [3:0]          nib;
  drive_state_t        sw_state;
  logic                sw_known;
  hb_state_t           hb_code;

  assign node_ext = {{(COB_ID_W-NODE_ID_W){1'b0}}, node_id};
  assign is_emcy  = frame.cob_id == (EMCY_BASE + node_ext);
  assign is_sdo   = frame.cob_id == (SDO_TX_BASE + node_ext);
  assign is_hb    = frame.cob_id == (HB_BASE + node_ext);
  assign sub_zero = frame.object_subindex == '0;
  assign nib      = frame.payload[3:0];

  always_comb begin
    sw_known = 1'b1;
    sw_state = cur.drive_state;
    unique case (nib)
      SW_NOT_READY: sw_state = frame.payload[SW_BIT_SOD] ? DS_SOD : DS_NOT_READY;
      SW_READY:     sw_state = DS_READY;
      SW_SWITCHED:  sw_state = DS_SWITCHED;
      SW_ENABLED:   sw_state = frame.payload[SW_BIT_QSTOP] ? DS_ENABLED : DS_QSTOP;
      SW_REACTION:  sw_state = DS_REACTION;
      SW_FAULT:     sw_state = DS_FAULT;
      default:      sw_known = 1'b0;
    endcase
  end

  always_comb begin
    unique case (frame.first_byte)
      NMT_BOOTUP:  hb_code = HB_BOOTUP;
      NMT_STOPPED: hb_code = HB_STOPPED;
      NMT_OPER:    hb_code = HB_OPER;
      NMT_PREOP:   hb_code = HB_PREOP;
      default:     hb_code = HB_OTHER;
    endcase
  end

  always_comb begin
    nxt   = cur;
    flags = '{frame_class: FC_UNKNOWN, status_unknown: 1'b0, heartbeat_state: HB_NONE};
    if (is_emcy) begin
      flags.frame_class = FC_EMCY;
      nxt.failed = 1'b1;
    end else if (is_sdo) begin
      flags.frame_class = FC_SDO;
      if (frame.object_index == OBJ_VELOCITY) begin
        nxt.velocity = signed'(frame.payload);
      end else if (frame.object_index == OBJ_TORQUE) begin
        nxt.torque = signed'(frame.payload[TORQUE_W-1:0]);
      end else if ((frame.object_index == OBJ_WARNING || frame.object_index == OBJ_ERROR)
                   && sub_zero) begin
        if (frame.payload[15:0] != '0) nxt.failed = 1'b1;
      end else if (frame.object_index == OBJ_STATUS && sub_zero) begin
        // unknown pattern keeps the previous state
        nxt.drive_state = sw_state;
        flags.status_unknown = !sw_known;
      end
    end else if (is_hb) begin
      flags.frame_class = FC_HB;
      flags.heartbeat_state = hb_code;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/canopen_drive_response_decoder_core.sv @@
// Top level of the CANopen drive response decoder: frame register, decode, result register,
// held drive state and the node-id register. Depends on cdrd_pkg, cdrd_frame_if,
// cdrd_result_if and cdrd_decode.
//
//   channel   dir  handshake            payload
//   frame     in   valid/ready          cob_id, first_byte, object_index, subindex, payload
//   result    out  valid/ready          class, velocity, torque, failed, states, flags
//   apb       in   psel/penable/pwrite  node_id at byte address 0
//
// One frame per cycle sustained while result.ready holds; a frame accepted into the frame register
// is decoded into the result register when that register advances, and its result is offered from there.
// The decode between frame register and result register bounds the cycle time.
// Reset (synchronous) empties both registers, clears held state, node_id = 1.
// A stalled result holds; the frame register still takes one more beat behind it.
`timescale 1ns / 1ps
`default_nettype none

module canopen_drive_response_decoder_core
  import cdrd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  cdrd_frame_if.sink              frame,
  cdrd_result_if.source           result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [NODE_ID_W-1:0] node_id;
  logic                 reg_hit;

  logic   s0_valid;
  frame_t s0_frame;
  logic   s0_adv;

  drive_t state;
  drive_t state_next;
  flags_t flags_next;

  logic   out_valid;
  drive_t out_drive;
  flags_t out_flags;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_NODE_ID;
  assign prdata  = reg_hit ? {{(PDATA_W-NODE_ID_W){1'b0}}, node_id} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= NODE_ID_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_id <= pwdata[NODE_ID_W-1:0];
    end
  end

  // Pipeline control
  assign s0_adv      = !out_valid || result.ready;
  assign frame.ready = !s0_valid || s0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (frame.ready) begin
      s0_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      s0_frame <= '{cob_id: frame.cob_id, first_byte: frame.first_byte,
                    object_index: frame.object_index,
                    object_subindex: frame.object_subindex, payload: frame.payload};
    end
  end

  cdrd_decode u_decode (
    .node_id (node_id),
    .frame   (s0_frame),
    .cur     (state),
    .nxt     (state_next),
    .flags   (flags_next)
  );

  // Advance held state and result together, one frame at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{velocity: '0, torque: '0, failed: 1'b0, drive_state: DS_NOT_READY};
      out_valid <= 1'b0;
    end else if (s0_adv) begin
      out_valid <= s0_valid;
      if (s0_valid) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && s0_valid) begin
      out_drive <= state_next;
      out_flags <= flags_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.frame_class     = out_flags.frame_class;
  assign result.velocity        = out_drive.velocity;
  assign result.torque          = out_drive.torque;
  assign result.failed          = out_drive.failed;
  assign result.drive_state     = out_drive.drive_state;
  assign result.status_unknown  = out_flags.status_unknown;
  assign result.heartbeat_state = out_flags.heartbeat_state;

  // Failure flag is sticky until reset
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    state.failed |=> state.failed)
    else $error("failure flag cleared without reset");

  // A waiting frame is never dropped while the result stalls
  a_s0_hold: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !s0_adv |=> s0_valid && $stable(s0_frame))
    else $error("frame register lost a beat under stall");

  a_unknown_sdo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.status_unknown |-> out_flags.frame_class == FC_SDO)
    else $error("status flag on a non-SDO frame");

  a_hb_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.heartbeat_state != HB_NONE |-> out_flags.frame_class == FC_HB)
    else $error("heartbeat state on a non-heartbeat frame");

  // Result shows the held state it was built from
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    s0_adv && s0_valid |=> out_drive == state)
    else $error("result and held state disagree");

endmodule

`default_nettype wire
